// ===== sv/nfha_pkg.sv =====
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared types and codes for the next-fit handle allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

    // Width of a handle on the command and result ports
    localparam int HANDLE_W = 8;

    // Operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_LOOKUP  = 2'd2;

    // Command transaction
    typedef struct packed {
        t_op                 operation;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    // Result transaction
    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        logic                success;
        logic                all_released;
    } t_result;

endpackage

// ===== sv/nfha_used_map.sv =====
// ----------------------------------------------------------------------------
// nfha_used_map
// One-bit-wide used-flag memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfha_used_map #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/next_fit_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// next_fit_handle_allocator_unit
// Next-fit handle allocator with allocate, release and lookup commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Allocate scans the
// used-flag memory one handle per cycle, starting after the last issued
// handle and wrapping past handle 0; the rate is set by the single memory
// read port feeding one compare per cycle. Release and lookup do one memory
// read, then the check and write-back. After reset the block sweeps the
// memory to clear it, with busy high. Each result shows on o_result for one
// cycle with o_done high and cannot be held off by the receiver;
// all_released reports whether no handle is in use after that command.
// ----------------------------------------------------------------------------
module next_fit_handle_allocator_unit
    import nfha_pkg::*;
#(
    parameter int HANDLE_COUNT = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int IDX_W  = $clog2(HANDLE_COUNT);
    localparam int WIDE_W = ((IDX_W > HANDLE_W) ? IDX_W : HANDLE_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HANDLE_COUNT - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CHECK
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_clr;
    logic [IDX_W-1:0]    r_last;
    logic [IDX_W-1:0]    r_chk;
    logic [IDX_W-1:0]    r_tries;
    logic [IDX_W-1:0]    r_used;
    t_op                 r_op;
    logic [HANDLE_W-1:0] r_h;
    logic                r_in_range;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic                mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic                mem_rdata;

    logic [WIDE_W-1:0]   h_wide;
    logic [WIDE_W-1:0]   rh_wide;
    logic [IDX_W-1:0]    h_idx;
    logic                h_in_range;
    logic                accept;
    logic                hit;

    // next candidate after a handle, skipping handle 0
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] h);
        logic [IDX_W-1:0] n;
        if (h == LAST_IDX) begin
            n = IDX_W'(1);
        end else begin
            n = h + IDX_W'(1);
        end
        return n;
    endfunction

    // command decode
    assign accept     = start && (r_state == S_IDLE);
    assign h_wide     = WIDE_W'(i_cmd.handle);
    assign rh_wide    = WIDE_W'(r_h);
    assign h_idx      = h_wide[IDX_W-1:0];
    assign h_in_range = (i_cmd.handle != '0) && (h_wide < WIDE_W'(HANDLE_COUNT));
    assign hit        = r_in_range && mem_rdata;
    assign busy       = (r_state != S_IDLE);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_chk;
        mem_wdata = 1'b0;
        mem_raddr = h_idx;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_IDLE: begin
                if (i_cmd.operation == OP_ALLOC) begin
                    mem_raddr = next_idx(r_last);
                end
            end
            S_SCAN: begin
                mem_raddr = next_idx(r_chk);
                if (!mem_rdata) begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                end
            end
            S_CHECK: begin
                mem_waddr = h_idx;
                if (r_op == OP_RELEASE && hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = rh_wide[IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    nfha_used_map #(
        .DEPTH  (HANDLE_COUNT),
        .ADDR_W (IDX_W)
    ) u_used_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer, state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_last  <= '0;
            r_used  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                // clear sweep after reset
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                // wait for a command; first read already issued
                S_IDLE: begin
                    if (accept) begin
                        r_op       <= i_cmd.operation;
                        r_h        <= i_cmd.handle;
                        r_in_range <= h_in_range;
                        r_chk      <= next_idx(r_last);
                        r_tries    <= IDX_W'(1);
                        if (i_cmd.operation == OP_ALLOC) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                // next-fit search, one candidate per cycle
                S_SCAN: begin
                    if (!mem_rdata) begin
                        r_used                 <= r_used + IDX_W'(1);
                        r_last                 <= r_chk;
                        o_done                 <= 1'b1;
                        o_result.result_handle <= HANDLE_W'(r_chk);
                        o_result.success       <= 1'b1;
                        o_result.all_released  <= 1'b0;
                        r_state                <= S_IDLE;
                    end else if (r_tries == LAST_IDX) begin
                        o_done                 <= 1'b1;
                        o_result.result_handle <= '0;
                        o_result.success       <= 1'b0;
                        o_result.all_released  <= (r_used == '0);
                        r_state                <= S_IDLE;
                    end else begin
                        r_chk   <= next_idx(r_chk);
                        r_tries <= r_tries + IDX_W'(1);
                    end
                end
                // release or lookup check
                S_CHECK: begin
                    o_done                 <= 1'b1;
                    o_result.result_handle <= r_h;
                    o_result.success       <= hit &&
                        ((r_op == OP_RELEASE) || (r_op == OP_LOOKUP));
                    if (r_op == OP_RELEASE && hit) begin
                        r_used                <= r_used - IDX_W'(1);
                        o_result.all_released <= (r_used == IDX_W'(1));
                    end else begin
                        o_result.all_released <= (r_used == '0);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
